// ===== rtl/core/deq_pkg.sv =====
// Package for the double-ended queue.
// Holds sizes, request and status codes, and the cell control type.
// No dependencies.
`default_nettype none

package deq_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int REQ_W      = 3;
	localparam int ST_W       = 2;
	localparam int VAL_W      = 32;
	localparam int CNT_OUT_W  = 7;
	localparam int GRP        = 8;
	localparam int NGRP       = (DEPTH + GRP - 1) / GRP;

	typedef logic [REQ_W-1:0]      req_t;
	typedef logic [ST_W-1:0]       status_t;
	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]      count_t;

	localparam req_t REQ_PUSH_FRONT = 3'd0;
	localparam req_t REQ_PUSH_BACK  = 3'd1;
	localparam req_t REQ_POP_FRONT  = 3'd2;
	localparam req_t REQ_POP_BACK   = 3'd3;
	localparam req_t REQ_PEEK_FRONT = 3'd4;
	localparam req_t REQ_PEEK_BACK  = 3'd5;
	localparam req_t REQ_CLEAR      = 3'd6;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_DATA  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;
	localparam status_t ST_FULL  = 2'd3;

	typedef logic [2:0] cell_op_t;

	localparam cell_op_t OP_HOLD   = 3'd0;
	localparam cell_op_t OP_SHR    = 3'd1;
	localparam cell_op_t OP_SHL    = 3'd2;
	localparam cell_op_t OP_PUSHB  = 3'd3;
	localparam cell_op_t OP_POPB   = 3'd4;
	localparam cell_op_t OP_CLEAR  = 3'd5;

	typedef struct packed {
		cell_op_t op;
		word_t    word;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/double_ended_queue_top.sv =====
// Top level of the double-ended queue: a chain of deq_cell instances with the
// front word in the first cell. Depends on deq_pkg and deq_cell.
// A request is accepted in idle state and run in exec state, where the back
// word is picked from registered group selects and the chain shifts or writes;
// exec waits while the last result is stalled, and no new request is taken
// until it ends. Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module double_ended_queue_top
	import deq_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire  [REQ_W-1:0]     req_type,
	input  wire  [VAL_W-1:0]     push_value,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [ST_W-1:0]      status,
	output logic [VAL_W-1:0]     read_value,
	output logic [CNT_OUT_W-1:0] entry_count
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic        state_q;
	req_t        req_q;
	word_t       word_q;
	count_t      count_q;
	logic        out_valid_q;
	status_t     status_q;
	logic [VAL_W-1:0] read_value_q;

	word_t       cell_data [DEPTH];
	logic        cell_valid [DEPTH];
	logic        cell_tail [DEPTH];
	word_t       grp_q [NGRP];
	word_t       grp_d [NGRP];
	word_t       back_word;
	cell_ctl_t   ctl;

	logic        finish;
	logic        is_empty;
	logic        is_full;
	status_t     status_d;
	word_t       rd_d;
	count_t      count_d;
	cell_op_t    op_d;

	logic [VAL_W+DATA_WIDTH-1:0]  push_ext;
	logic [DATA_WIDTH+VAL_W-1:0]  rd_ext;
	logic [CNT_W+CNT_OUT_W-1:0]   cnt_ext;

	assign push_ext = {{DATA_WIDTH{1'b0}}, push_value};
	assign rd_ext   = {{VAL_W{1'b0}}, rd_d};
	assign cnt_ext  = {{CNT_OUT_W{1'b0}}, count_q};

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign entry_count = cnt_ext[CNT_OUT_W-1:0];

	assign finish   = (state_q == S_EXEC) && (!out_valid_q || !out_stall);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == count_t'(DEPTH));

	assign ctl.op   = finish ? op_d : OP_HOLD;
	assign ctl.word = word_q;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			word_t l_data;
			logic  l_valid;
			word_t r_data;
			logic  r_valid;
			if (gi == 0) begin : g_first
				assign l_data  = word_q;
				assign l_valid = 1'b1;
			end else begin : g_mid_l
				assign l_data  = cell_data[gi-1];
				assign l_valid = cell_valid[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign r_data  = '0;
				assign r_valid = 1'b0;
			end else begin : g_mid_r
				assign r_data  = cell_data[gi+1];
				assign r_valid = cell_valid[gi+1];
			end
			deq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.left_data   (l_data),
				.left_valid  (l_valid),
				.right_data  (r_data),
				.right_valid (r_valid),
				.data        (cell_data[gi]),
				.valid       (cell_valid[gi]),
				.tail        (cell_tail[gi])
			);
		end
	endgenerate

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < DEPTH) begin
					if (cell_tail[g * GRP + k]) begin
						grp_d[g] = grp_d[g] | cell_data[g * GRP + k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_q[g] <= grp_d[g];
		end
	end

	always_comb begin
		back_word = '0;
		for (int g = 0; g < NGRP; g++) begin
			back_word = back_word | grp_q[g];
		end
	end

	always_comb begin
		status_d = ST_OK;
		rd_d     = '0;
		count_d  = count_q;
		op_d     = OP_HOLD;
		unique case (req_q)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = (req_q == REQ_PUSH_FRONT) ? OP_SHR : OP_PUSHB;
					count_d = count_q + count_t'(1);
				end
			end
			REQ_POP_FRONT, REQ_PEEK_FRONT: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					status_d = ST_DATA;
					rd_d     = cell_data[0];
					if (req_q == REQ_POP_FRONT) begin
						op_d    = OP_SHL;
						count_d = count_q - count_t'(1);
					end
				end
			end
			REQ_POP_BACK, REQ_PEEK_BACK: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					status_d = ST_DATA;
					rd_d     = back_word;
					if (req_q == REQ_POP_BACK) begin
						op_d    = OP_POPB;
						count_d = count_q - count_t'(1);
					end
				end
			end
			REQ_CLEAR: begin
				op_d    = OP_CLEAR;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (finish) begin
						state_q     <= S_IDLE;
						count_q     <= count_d;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q  <= req_type;
			word_q <= push_ext[DATA_WIDTH-1:0];
		end
		if (finish) begin
			status_q     <= status_d;
			read_value_q <= rd_ext[VAL_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/deq_cell.sv =====
// One storage cell of the queue chain: a word and its valid flag.
// Takes data from either neighbor on a shift. Depends on deq_pkg.
`default_nettype none

module deq_cell
	import deq_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  cell_ctl_t  ctl,
	input  word_t      left_data,
	input  wire        left_valid,
	input  word_t      right_data,
	input  wire        right_valid,
	output word_t      data,
	output logic       valid,
	output logic       tail
);

	word_t data_q;
	logic  valid_q;

	assign data  = data_q;
	assign valid = valid_q;
	assign tail  = valid_q && !right_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				OP_SHR: begin
					valid_q <= left_valid;
				end
				OP_SHL: begin
					valid_q <= right_valid;
				end
				OP_PUSHB: begin
					if (!valid_q && left_valid) begin
						valid_q <= 1'b1;
					end
				end
				OP_POPB: begin
					if (tail) begin
						valid_q <= 1'b0;
					end
				end
				OP_CLEAR: begin
					valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_SHR: begin
				data_q <= left_data;
			end
			OP_SHL: begin
				data_q <= right_data;
			end
			OP_PUSHB: begin
				if (!valid_q && left_valid) begin
					data_q <= ctl.word;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== bench/deq_checker.sv =====
// Checker for the double-ended queue: watches both channels, keeps a ring model
// of its contents, predicts each result and compares it with the block's result.
// Depends on deq_pkg for sizes, request codes and status codes.

module deq_checker
	import deq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [VAL_W-1:0]     push_value,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [ST_W-1:0]      status,
	input  logic [VAL_W-1:0]     read_value,
	input  logic [CNT_OUT_W-1:0] entry_count,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t              st;
		logic [VAL_W-1:0]     rd;
		logic [CNT_OUT_W-1:0] cnt;
	} deq_result_t;

	deq_result_t expected_results[$];
	word_t       ring_words[DEPTH];
	int          front_pos = 0;
	int          used = 0;

	function automatic deq_result_t apply_request(input req_t rq, input logic [VAL_W-1:0] val);
		deq_result_t r;
		int          pos;
		r.st = ST_OK;
		r.rd = '0;
		case (rq)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (used >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					if (rq == REQ_PUSH_FRONT) begin
						front_pos = (front_pos + DEPTH - 1) % DEPTH;
						ring_words[front_pos] = word_t'(val);
					end else begin
						ring_words[(front_pos + used) % DEPTH] = word_t'(val);
					end
					used++;
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
				if (used == 0) begin
					r.st = ST_EMPTY;
				end else begin
					if (rq == REQ_POP_FRONT || rq == REQ_PEEK_FRONT)
						pos = front_pos;
					else
						pos = (front_pos + used - 1) % DEPTH;
					r.rd = VAL_W'(ring_words[pos]);
					r.st = ST_DATA;
					if (rq == REQ_POP_FRONT) begin
						front_pos = (front_pos + 1) % DEPTH;
						used--;
					end else if (rq == REQ_POP_BACK) begin
						used--;
					end
				end
			end
			REQ_CLEAR: begin
				used = 0;
				front_pos = 0;
			end
			default: ;
		endcase
		r.cnt = CNT_OUT_W'(used);
		return r;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		deq_result_t exp_r;
		if (!arst_n) begin
			expected_results.delete();
			front_pos = 0;
			used = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("word returned with no request waiting: status %0d", status);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (status !== exp_r.st) begin
						$error("status: expected %0d, actual %0d", exp_r.st, status);
						fail_count++;
					end
					if (read_value !== exp_r.rd) begin
						$error("read_value: expected %h, actual %h", exp_r.rd, read_value);
						fail_count++;
					end
					if (entry_count !== exp_r.cnt) begin
						$error("entry_count: expected %0d, actual %0d", exp_r.cnt, entry_count);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(apply_request(req_type, push_value));
		end
		pending = expected_results.size();
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the double-ended queue testbench: clock, reset and request stimulus,
// with random idling on both sides. Depends on deq_pkg, double_ended_queue_top
// and deq_checker, which does all prediction and comparison.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import deq_pkg::*;

	localparam req_t REQ_UNUSED   = 3'd7;
	localparam int   RANDOM_WORDS = 1450;
	localparam int   PHASE_LEN    = 120;
	localparam int   HOLD_CYCLES  = 400;
	localparam int   HOLD_AFTER   = 300;

	localparam int BIAS_PUSH = 0;
	localparam int BIAS_MIX  = 1;
	localparam int BIAS_POP  = 2;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 out_stall = 1'b0;
	logic [REQ_W-1:0]     req_type = '0;
	logic [VAL_W-1:0]     push_value = '0;
	logic                 in_stall;
	logic                 out_valid;
	logic [ST_W-1:0]      status;
	logic [VAL_W-1:0]     read_value;
	logic [CNT_OUT_W-1:0] entry_count;

	int fail_count;
	int pending;
	int words_sent = 0;
	bit quiet = 1'b0;
	bit hold_done = 1'b0;

	always #4 clk = ~clk;

	double_ended_queue_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.push_value  (push_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count)
	);

	deq_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.push_value  (push_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	task automatic offer_word(input req_t rq, input logic [VAL_W-1:0] val);
		while (!quiet && $urandom_range(99) < 32) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = rq;
		push_value = val;
		do @(posedge clk); while (in_stall);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic logic [VAL_W-1:0] random_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return VAL_W'(1) << $urandom_range(VAL_W - 1);
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic req_t pick_request(input int bias);
		int r;
		int push_pct;
		r = $urandom_range(99);
		if (bias == BIAS_MIX && r < 2)
			return REQ_CLEAR;
		if (r == 2)
			return REQ_UNUSED;
		push_pct = (bias == BIAS_PUSH) ? 85 : (bias == BIAS_POP) ? 15 : 45;
		if (r < 3 + push_pct)
			return $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
		case ($urandom_range(5))
			0, 1: return REQ_POP_FRONT;
			2, 3: return REQ_POP_BACK;
			4: return REQ_PEEK_FRONT;
			default: return REQ_PEEK_BACK;
		endcase
	endfunction

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && words_sent >= HOLD_AFTER) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			out_stall = !quiet && ($urandom_range(99) < 32);
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reads of an empty queue must be refused without touching state; then pushes, pops, peeks, a clear.
		offer_word(REQ_PEEK_FRONT, 32'h1234_5678);
		offer_word(REQ_PEEK_BACK,  32'hFFFF_FFFF);
		offer_word(REQ_POP_FRONT,  32'hDEAD_BEEF);
		offer_word(REQ_POP_BACK,   32'h0000_0001);
		offer_word(REQ_PUSH_FRONT, 32'h0000_0000);
		offer_word(REQ_PUSH_BACK,  32'hFFFF_FFFF);
		offer_word(REQ_PEEK_FRONT, 32'h0);
		offer_word(REQ_PEEK_BACK,  32'h0);
		offer_word(REQ_PUSH_FRONT, 32'h8000_0001);
		offer_word(REQ_PUSH_BACK,  32'h7FFF_FFFE);
		offer_word(REQ_POP_BACK,   32'h0);
		offer_word(REQ_POP_FRONT,  32'h0);
		offer_word(REQ_PEEK_BACK,  32'h0);
		offer_word(REQ_UNUSED,     32'hAAAA_AAAA);
		offer_word(REQ_CLEAR,      32'h5555_5555);
		offer_word(REQ_POP_BACK,   32'h0);
		offer_word(REQ_PUSH_BACK,  32'h5555_5555);
		offer_word(REQ_PUSH_FRONT, 32'h0000_0001);
		offer_word(REQ_POP_FRONT,  32'h0);
		offer_word(REQ_POP_FRONT,  32'h0);
		offer_word(REQ_POP_FRONT,  32'h0);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			quiet = (i >= 500 && i < 700);
			offer_word(pick_request((i / PHASE_LEN) % 3), random_word());
		end
		quiet = 1'b0;
		in_valid = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
